// ----- sv/hscip_pkg.sv -----
// shared types, codes and constants of the sps color info parser
`default_nettype none
package hscip_pkg;

    // width of the reference picture counts
    localparam int COUNT_WIDTH = 32;
    localparam logic [32:0] COUNT_MAX = 33'((64'h1 << COUNT_WIDTH) - 64'h1);

    localparam logic [31:0] AR_EXTENDED = 32'hFF;
    localparam logic [31:0] TRC_PQ      = 32'd16;
    localparam logic [31:0] TRC_HLG     = 32'd18;
    localparam logic [6:0]  PTL_BITS    = 7'd96;
    localparam logic [6:0]  SUB_PROF    = 7'd88;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic       parse_status;
        logic [3:0] present_mask;
        logic [7:0] chroma_format;
        logic [7:0] luma_depth_minus8;
        logic [7:0] chroma_depth_minus8;
        logic       full_range;
        logic [7:0] colour_primaries;
        logic [7:0] transfer_code;
        logic [7:0] matrix_code;
        logic       has_colour_desc;
        logic       is_hdr;
    } out_t;

    // bit reader operations
    typedef enum logic [2:0] {
        RO_NONE, RO_SHIFT, RO_ZERO_INC, RO_SUFFIX_START, RO_WANT_BITS, RO_WANT_UE
    } rd_op_t;

    // decoded value capture
    typedef enum logic [1:0] {CAP_NONE, CAP_BITS, CAP_ZERO, CAP_UE} cap_t;

    // fixed length read sizes
    typedef enum logic [3:0] {
        LEN_1, LEN_2, LEN_3, LEN_8, LEN_32, LEN_PTL, LEN_PAD, LEN_SUB, LEN_LT
    } len_t;

    typedef enum logic [2:0] {
        LI_NONE, LI_ZERO, LI_INC, LI_DEC, LI_SET4, LI_SET2, LI_ORD, LI_SLC
    } li_op_t;

    typedef enum logic [1:0] {SF_NONE, SF_CLEAR, SF_OR} sf_op_t;
    typedef enum logic [1:0] {PC_NONE, PC_ZERO, PC_SUM, PC_NEXT} pc_op_t;
    typedef enum logic [1:0] {NP_NONE, NP_ZERO, NP_INC, NP_LOAD} np_op_t;
    typedef enum logic [1:0] {CT_NONE, CT_ZERO, CT_INC} ct_op_t;

    typedef enum logic [3:0] {
        PUT_NONE, PUT_CHROMA, PUT_LUMA, PUT_CHDEPTH, PUT_FR, PUT_CD,
        PUT_PRIM, PUT_TRC, PUT_MAT
    } put_t;

    typedef struct packed {
        logic   load_byte;
        logic   shift_bit;
        rd_op_t ro;
        cap_t   cap;
        len_t   len;
        li_op_t li;
        sf_op_t sf;
        pc_op_t pc;
        np_op_t np;
        ct_op_t pidx;
        ct_op_t sp;
        logic   sc_load;
        logic   limit_load;
        logic   poc_load;
        put_t   put;
        logic   err_set;
        logic   clear;
        logic   out_load;
        logic   rd_busy;
    } cmd_t;

    typedef struct packed {
        logic cur_bit;
        logic bits_left;
        logic skip_one;
        logic zeros_zero;
        logic zeros_max;
        logic v_nz;
        logic v_bit0;
        logic v_eq3;
        logic v_eq_ff;
        logic v_over;
        logic sc_zero;
        logic li_next_lt_sc;
        logic li_lt_sc;
        logic sub_len_nz;
        logic li_is_one;
        logic li_nz;
        logic li_ge_limit;
        logic li_next_lt_limit;
        logic npc_inc_over;
        logic sum_over;
        logic sum_nz;
        logic pidx_next_le_pic;
        logic pidx_next_lt_pic;
        logic sp_next_lt20;
    } sts_t;

endpackage
`default_nettype wire

// ----- sv/hscip_dp.sv -----
// datapath: byte shifter, bit reader, loop counters and result registers
`default_nettype none
module hscip_dp (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hscip_pkg::in_t  in_data,
    input  wire hscip_pkg::cmd_t cmd,
    output hscip_pkg::sts_t      sts,
    output hscip_pkg::out_t      out_data
);
    import hscip_pkg::*;

    localparam int CW = COUNT_WIDTH;

    logic [7:0]    byte_reg;
    logic [3:0]    bitcnt_reg;
    logic [6:0]    skip_reg;
    logic [4:0]    zeros_reg;
    logic [31:0]   val_reg;
    logic [31:0]   run_val_reg;
    logic [2:0]    sc_reg;
    logic [15:0]   sf_reg;
    logic [CW-1:0] li_reg;
    logic [CW-1:0] limit_reg;
    logic [CW-1:0] pic_reg;
    logic [31:0]   npc_reg;
    logic [CW:0]   pidx_reg;
    logic [5:0]    poc_reg;
    logic [4:0]    sp_reg;
    logic [7:0]    chroma_reg, luma_reg, chd_reg, prim_reg, trc_reg, mat_reg;
    logic [3:0]    present_reg;
    logic          fr_reg, cd_reg, hdr_reg, err_reg;
    out_t          out_reg;

    logic          bit_in;
    logic [31:0]   shifted;
    logic [31:0]   ue_val;
    logic [32:0]   sum;
    logic [3:0]    sub_sh;
    logic [1:0]    sub_f;
    logic [6:0]    sub_len;
    logic [6:0]    pad_len;
    logic [6:0]    lt_len;
    logic [6:0]    len_val;
    logic [5:0]    ord_cnt;
    logic [6:0]    slc_cnt;
    logic [1:0]    size_id;
    logic [CW-1:0] li_next;
    logic [CW:0]   pidx_next;
    logic [7:0]    v_sat;

    // bit reader arithmetic
    assign bit_in  = byte_reg[7];
    assign shifted = {val_reg[30:0], bit_in};
    assign ue_val  = ((32'd1 << zeros_reg) - 32'd1) + shifted;
    assign sum     = {1'b0, npc_reg} + {1'b0, run_val_reg};
    assign li_next = li_reg + CW'(1);
    assign pidx_next = pidx_reg + (CW+1)'(1);
    assign v_sat   = (run_val_reg > 32'd255) ? 8'hFF : run_val_reg[7:0];

    // sub-layer profile/level skip length
    assign sub_sh  = {li_reg[2:0], 1'b0};
    assign sub_f   = sf_reg[sub_sh +: 2];
    assign sub_len = (sub_f[1] ? SUB_PROF : 7'd0) + (sub_f[0] ? 7'd8 : 7'd0);
    assign pad_len = 7'd16 - {3'd0, sc_reg, 1'b0};
    assign lt_len  = {1'b0, poc_reg} + 7'd1;
    assign ord_cnt = 6'(({3'd0, sc_reg} + 6'd1) * 6'd3 + 6'd6);

    // scaling list coefficient count per size class
    always_comb begin
        if (sp_reg < 5'd6) size_id = 2'd0;
        else if (sp_reg < 5'd12) size_id = 2'd1;
        else if (sp_reg < 5'd18) size_id = 2'd2;
        else size_id = 2'd3;
        slc_cnt = ((size_id == 2'd0) ? 7'd16 : 7'd64) + ((size_id > 2'd1) ? 7'd1 : 7'd0);
    end

    // read length select
    always_comb begin
        case (cmd.len)
            LEN_1:   len_val = 7'd1;
            LEN_2:   len_val = 7'd2;
            LEN_3:   len_val = 7'd3;
            LEN_8:   len_val = 7'd8;
            LEN_32:  len_val = 7'd32;
            LEN_PTL: len_val = PTL_BITS + 7'd1;
            LEN_PAD: len_val = pad_len;
            LEN_SUB: len_val = sub_len;
            LEN_LT:  len_val = lt_len;
            default: len_val = 7'd1;
        endcase
    end

    // status to the controller
    always_comb begin
        sts.cur_bit          = bit_in;
        sts.bits_left        = (bitcnt_reg != 4'd0);
        sts.skip_one         = (skip_reg == 7'd1);
        sts.zeros_zero       = (zeros_reg == 5'd0);
        sts.zeros_max        = (zeros_reg == 5'd31);
        sts.v_nz             = (run_val_reg != 32'd0);
        sts.v_bit0           = run_val_reg[0];
        sts.v_eq3            = (run_val_reg == 32'd3);
        sts.v_eq_ff          = (run_val_reg == AR_EXTENDED);
        sts.v_over           = ({1'b0, run_val_reg} > COUNT_MAX);
        sts.sc_zero          = (sc_reg == 3'd0);
        sts.li_next_lt_sc    = (li_next < CW'(sc_reg));
        sts.li_lt_sc         = (li_reg < CW'(sc_reg));
        sts.sub_len_nz       = (sub_len != 7'd0);
        sts.li_is_one        = (li_reg == CW'(1));
        sts.li_nz            = (li_reg != '0);
        sts.li_ge_limit      = (li_reg >= limit_reg);
        sts.li_next_lt_limit = (li_next < limit_reg);
        sts.npc_inc_over     = ({1'b0, npc_reg} + 33'd1 > COUNT_MAX);
        sts.sum_over         = (sum > COUNT_MAX);
        sts.sum_nz           = (sum != 33'd0);
        sts.pidx_next_le_pic = (pidx_next <= {1'b0, pic_reg});
        sts.pidx_next_lt_pic = (pidx_next < {1'b0, pic_reg});
        sts.sp_next_lt20     = (sp_reg + 5'd1 < 5'd20);
    end

    // byte shifter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitcnt_reg <= 4'd0;
        end else if (cmd.load_byte) begin
            bitcnt_reg <= 4'd8;
        end else if (cmd.shift_bit) begin
            bitcnt_reg <= bitcnt_reg - 4'd1;
        end
        if (cmd.load_byte) begin
            byte_reg <= in_data.payload_byte;
        end else if (cmd.shift_bit) begin
            byte_reg <= {byte_reg[6:0], 1'b0};
        end
    end

    // parse state and results
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            skip_reg    <= 7'd4;
            zeros_reg   <= 5'd0;
            val_reg     <= 32'd0;
            run_val_reg <= 32'd0;
            sc_reg      <= 3'd0;
            sf_reg      <= 16'd0;
            li_reg      <= '0;
            limit_reg   <= '0;
            pic_reg     <= '0;
            npc_reg     <= 32'd0;
            pidx_reg    <= '0;
            poc_reg     <= 6'd4;
            sp_reg      <= 5'd0;
            chroma_reg  <= 8'd0;
            luma_reg    <= 8'd0;
            chd_reg     <= 8'd0;
            prim_reg    <= 8'd0;
            trc_reg     <= 8'd0;
            mat_reg     <= 8'd0;
            present_reg <= 4'd0;
            fr_reg      <= 1'b0;
            cd_reg      <= 1'b0;
            hdr_reg     <= 1'b0;
            err_reg     <= 1'b0;
        end else begin
            // bit reader
            case (cmd.ro)
                RO_SHIFT: begin
                    val_reg  <= shifted;
                    skip_reg <= skip_reg - 7'd1;
                end
                RO_ZERO_INC: zeros_reg <= zeros_reg + 5'd1;
                RO_SUFFIX_START: begin
                    skip_reg <= {2'd0, zeros_reg};
                    val_reg  <= 32'd0;
                end
                RO_WANT_BITS: begin
                    skip_reg <= len_val;
                    val_reg  <= 32'd0;
                end
                RO_WANT_UE: begin
                    zeros_reg <= 5'd0;
                    val_reg   <= 32'd0;
                end
                default: ;
            endcase
            case (cmd.cap)
                CAP_BITS: run_val_reg <= shifted;
                CAP_ZERO: run_val_reg <= 32'd0;
                CAP_UE:   run_val_reg <= ue_val;
                default: ;
            endcase
            // loop counters
            case (cmd.li)
                LI_ZERO: li_reg <= '0;
                LI_INC:  li_reg <= li_next;
                LI_DEC:  li_reg <= li_reg - CW'(1);
                LI_SET4: li_reg <= CW'(4);
                LI_SET2: li_reg <= CW'(2);
                LI_ORD:  li_reg <= run_val_reg[0] ? CW'(ord_cnt) : CW'(9);
                LI_SLC:  li_reg <= CW'(slc_cnt);
                default: ;
            endcase
            case (cmd.sf)
                SF_CLEAR: sf_reg <= 16'd0;
                SF_OR:    sf_reg <= sf_reg | (16'(run_val_reg[1:0]) << sub_sh);
                default: ;
            endcase
            case (cmd.pc)
                PC_ZERO: pic_reg <= '0;
                PC_SUM:  pic_reg <= sum[CW-1:0];
                PC_NEXT: pic_reg <= npc_reg[CW-1:0];
                default: ;
            endcase
            case (cmd.np)
                NP_ZERO: npc_reg <= 32'd0;
                NP_INC:  npc_reg <= npc_reg + 32'd1;
                NP_LOAD: npc_reg <= run_val_reg;
                default: ;
            endcase
            case (cmd.pidx)
                CT_ZERO: pidx_reg <= '0;
                CT_INC:  pidx_reg <= pidx_next;
                default: ;
            endcase
            case (cmd.sp)
                CT_ZERO: sp_reg <= 5'd0;
                CT_INC:  sp_reg <= sp_reg + 5'd1;
                default: ;
            endcase
            if (cmd.sc_load) sc_reg <= run_val_reg[2:0];
            if (cmd.limit_load) limit_reg <= run_val_reg[CW-1:0];
            if (cmd.poc_load) begin
                poc_reg <= (run_val_reg > 32'd59) ? 6'd63 : run_val_reg[5:0] + 6'd4;
            end
            if (cmd.err_set) err_reg <= 1'b1;
            // result fields
            case (cmd.put)
                PUT_CHROMA:  chroma_reg <= v_sat;
                PUT_LUMA:    luma_reg <= v_sat;
                PUT_CHDEPTH: chd_reg <= v_sat;
                PUT_FR: begin
                    fr_reg         <= run_val_reg[0];
                    present_reg[0] <= 1'b1;
                end
                PUT_CD: cd_reg <= 1'b1;
                PUT_PRIM: begin
                    prim_reg       <= run_val_reg[7:0];
                    present_reg[1] <= 1'b1;
                end
                PUT_TRC: begin
                    trc_reg        <= run_val_reg[7:0];
                    present_reg[2] <= 1'b1;
                    if (run_val_reg == TRC_PQ || run_val_reg == TRC_HLG) hdr_reg <= 1'b1;
                end
                PUT_MAT: begin
                    mat_reg        <= run_val_reg[7:0];
                    present_reg[3] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.parse_status        <= err_reg | cmd.rd_busy;
            out_reg.present_mask        <= present_reg;
            out_reg.chroma_format       <= chroma_reg;
            out_reg.luma_depth_minus8   <= luma_reg;
            out_reg.chroma_depth_minus8 <= chd_reg;
            out_reg.full_range          <= fr_reg;
            out_reg.colour_primaries    <= prim_reg;
            out_reg.transfer_code       <= trc_reg;
            out_reg.matrix_code         <= mat_reg;
            out_reg.has_colour_desc     <= cd_reg;
            out_reg.is_hdr              <= hdr_reg;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

// ----- sv/hscip_ctrl.sv -----
// controller: sps syntax state machine, read sequencing and handshakes
`default_nettype none
module hscip_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_last,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire hscip_pkg::sts_t  sts,
    output hscip_pkg::cmd_t       cmd
);
    import hscip_pkg::*;

    typedef enum logic [55:0] {
        S_VPS       = 56'd1 << 0,  S_MAXSUB    = 56'd1 << 1,
        S_PTL       = 56'd1 << 2,  S_SUBFLAGS  = 56'd1 << 3,
        S_SUBPAD    = 56'd1 << 4,  S_SUBLOOP   = 56'd1 << 5,
        S_SPSID     = 56'd1 << 6,  S_CHROMA    = 56'd1 << 7,
        S_SEPCOL    = 56'd1 << 8,  S_WIDTH     = 56'd1 << 9,
        S_HEIGHT    = 56'd1 << 10, S_CONF      = 56'd1 << 11,
        S_CONFW     = 56'd1 << 12, S_LUMA      = 56'd1 << 13,
        S_CHDEPTH   = 56'd1 << 14, S_POC       = 56'd1 << 15,
        S_ORDFLAG   = 56'd1 << 16, S_ORD       = 56'd1 << 17,
        S_SLEN      = 56'd1 << 18, S_SLDATA    = 56'd1 << 19,
        S_SLPRED    = 56'd1 << 20, S_SLCOEF    = 56'd1 << 21,
        S_SLNEXT    = 56'd1 << 22, S_PCM       = 56'd1 << 23,
        S_PCMB      = 56'd1 << 24, S_PCMU      = 56'd1 << 25,
        S_PCMLF     = 56'd1 << 26, S_NUMST     = 56'd1 << 27,
        S_RPS       = 56'd1 << 28, S_INTERFLAG = 56'd1 << 29,
        S_DRSIGN    = 56'd1 << 30, S_ADRPS     = 56'd1 << 31,
        S_USEDCURR  = 56'd1 << 32, S_USEDELTA  = 56'd1 << 33,
        S_JNEXT     = 56'd1 << 34, S_NNEG      = 56'd1 << 35,
        S_NPOS      = 56'd1 << 36, S_DPOC      = 56'd1 << 37,
        S_DUSED     = 56'd1 << 38, S_LTFLAG    = 56'd1 << 39,
        S_NUMLT     = 56'd1 << 40, S_LT        = 56'd1 << 41,
        S_VUI       = 56'd1 << 42, S_ARFLAG    = 56'd1 << 43,
        S_ARIDC     = 56'd1 << 44, S_SAR       = 56'd1 << 45,
        S_OVFLAG    = 56'd1 << 46, S_OVAPP     = 56'd1 << 47,
        S_VSFLAG    = 56'd1 << 48, S_VFMT      = 56'd1 << 49,
        S_FR        = 56'd1 << 50, S_CDFLAG    = 56'd1 << 51,
        S_PRIM      = 56'd1 << 52, S_TRC       = 56'd1 << 53,
        S_MAT       = 56'd1 << 54, S_DONE      = 56'd1 << 55
    } syn_state_t;

    typedef enum logic [3:0] {
        RD_IDLE = 4'b0001, RD_BITS = 4'b0010, RD_PREFIX = 4'b0100, RD_SUFFIX = 4'b1000
    } rd_state_t;

    typedef enum logic [2:0] {A_NONE, A_GO, A_BITS, A_UE, A_STOP, A_STOP_ERR} act_t;

    syn_state_t syn_reg, syn_next;
    rd_state_t  rd_reg, rd_next;
    logic       pend_reg, pend_next;
    logic       fin_reg, fin_next;
    logic       mval_reg, mval_next;

    assign s_ready = !pend_reg && !sts.bits_left && !fin_reg;
    assign m_valid = mval_reg;

    always_comb begin
        act_t       act;
        syn_state_t tgt;
        len_t       len;
        syn_next  = syn_reg;
        rd_next   = rd_reg;
        pend_next = pend_reg;
        fin_next  = fin_reg;
        mval_next = mval_reg && !m_ready;
        cmd       = '0;
        act       = A_NONE;
        tgt       = syn_reg;
        len       = LEN_1;
        cmd.rd_busy = (rd_reg != RD_IDLE);

        if (pend_reg) begin
            // one syntax step on the value just read
            case (syn_reg)
                S_VPS: begin act = A_BITS; len = LEN_3; tgt = S_MAXSUB; end
                S_MAXSUB: begin
                    cmd.sc_load = 1'b1;
                    act = A_BITS; len = LEN_PTL; tgt = S_PTL;
                end
                S_PTL: begin
                    cmd.sf = SF_CLEAR; cmd.li = LI_ZERO;
                    if (sts.sc_zero) begin act = A_UE; tgt = S_SPSID; end
                    else begin act = A_BITS; len = LEN_2; tgt = S_SUBFLAGS; end
                end
                S_SUBFLAGS: begin
                    cmd.sf = SF_OR; cmd.li = LI_INC;
                    act = A_BITS;
                    if (sts.li_next_lt_sc) begin len = LEN_2; tgt = S_SUBFLAGS; end
                    else begin len = LEN_PAD; tgt = S_SUBPAD; end
                end
                S_SUBPAD: begin cmd.li = LI_ZERO; act = A_GO; tgt = S_SUBLOOP; end
                S_SUBLOOP: begin
                    if (sts.li_lt_sc) begin
                        cmd.li = LI_INC;
                        if (sts.sub_len_nz) begin
                            act = A_BITS; len = LEN_SUB; tgt = S_SUBLOOP;
                        end
                    end else begin
                        act = A_UE; tgt = S_SPSID;
                    end
                end
                S_SPSID: begin act = A_UE; tgt = S_CHROMA; end
                S_CHROMA: begin
                    cmd.put = PUT_CHROMA;
                    if (sts.v_eq3) begin act = A_BITS; tgt = S_SEPCOL; end
                    else begin act = A_UE; tgt = S_WIDTH; end
                end
                S_SEPCOL: begin act = A_UE; tgt = S_WIDTH; end
                S_WIDTH: begin act = A_UE; tgt = S_HEIGHT; end
                S_HEIGHT: begin act = A_BITS; tgt = S_CONF; end
                S_CONF: begin
                    act = A_UE;
                    if (sts.v_nz) begin cmd.li = LI_SET4; tgt = S_CONFW; end
                    else tgt = S_LUMA;
                end
                S_CONFW: begin
                    cmd.li = LI_DEC; act = A_UE;
                    tgt = sts.li_is_one ? S_LUMA : S_CONFW;
                end
                S_LUMA: begin cmd.put = PUT_LUMA; act = A_UE; tgt = S_CHDEPTH; end
                S_CHDEPTH: begin cmd.put = PUT_CHDEPTH; act = A_UE; tgt = S_POC; end
                S_POC: begin cmd.poc_load = 1'b1; act = A_BITS; tgt = S_ORDFLAG; end
                S_ORDFLAG: begin cmd.li = LI_ORD; act = A_UE; tgt = S_ORD; end
                S_ORD: begin
                    cmd.li = LI_DEC;
                    if (sts.li_is_one) begin act = A_BITS; tgt = S_SLEN; end
                    else begin act = A_UE; tgt = S_ORD; end
                end
                S_SLEN: begin
                    act = A_BITS;
                    if (sts.v_nz) tgt = S_SLDATA;
                    else begin len = LEN_3; tgt = S_PCM; end
                end
                S_SLDATA: begin
                    act = A_BITS;
                    if (sts.v_nz) begin cmd.sp = CT_ZERO; tgt = S_SLPRED; end
                    else begin len = LEN_3; tgt = S_PCM; end
                end
                S_SLPRED: begin
                    act = A_UE;
                    if (!sts.v_nz) tgt = S_SLNEXT;
                    else begin cmd.li = LI_SLC; tgt = S_SLCOEF; end
                end
                S_SLCOEF: begin
                    cmd.li = LI_DEC;
                    if (sts.li_is_one) begin act = A_GO; tgt = S_SLNEXT; end
                    else begin act = A_UE; tgt = S_SLCOEF; end
                end
                S_SLNEXT: begin
                    cmd.sp = CT_INC; act = A_BITS;
                    if (sts.sp_next_lt20) tgt = S_SLPRED;
                    else begin len = LEN_3; tgt = S_PCM; end
                end
                S_PCM: begin
                    if (sts.v_bit0) begin act = A_BITS; len = LEN_8; tgt = S_PCMB; end
                    else begin act = A_UE; tgt = S_NUMST; end
                end
                S_PCMB: begin cmd.li = LI_SET2; act = A_UE; tgt = S_PCMU; end
                S_PCMU: begin
                    cmd.li = LI_DEC;
                    if (sts.li_is_one) begin act = A_BITS; tgt = S_PCMLF; end
                    else begin act = A_UE; tgt = S_PCMU; end
                end
                S_PCMLF: begin act = A_UE; tgt = S_NUMST; end
                S_NUMST: begin
                    if (sts.v_over) act = A_STOP_ERR;
                    else begin
                        cmd.limit_load = 1'b1; cmd.li = LI_ZERO; cmd.pc = PC_ZERO;
                        act = A_GO; tgt = S_RPS;
                    end
                end
                S_RPS: begin
                    if (sts.li_ge_limit) begin act = A_BITS; tgt = S_LTFLAG; end
                    else if (sts.li_nz) begin act = A_BITS; tgt = S_INTERFLAG; end
                    else begin act = A_UE; tgt = S_NNEG; end
                end
                S_INTERFLAG: begin
                    if (sts.v_nz) begin act = A_BITS; tgt = S_DRSIGN; end
                    else begin act = A_UE; tgt = S_NNEG; end
                end
                S_DRSIGN: begin act = A_UE; tgt = S_ADRPS; end
                S_ADRPS: begin
                    cmd.np = NP_ZERO; cmd.pidx = CT_ZERO;
                    act = A_BITS; tgt = S_USEDCURR;
                end
                S_USEDCURR, S_USEDELTA: begin
                    if (sts.v_nz) begin
                        if (sts.npc_inc_over) act = A_STOP_ERR;
                        else begin cmd.np = NP_INC; act = A_GO; tgt = S_JNEXT; end
                    end else if (syn_reg == S_USEDCURR) begin
                        act = A_BITS; tgt = S_USEDELTA;
                    end else begin
                        act = A_GO; tgt = S_JNEXT;
                    end
                end
                S_JNEXT: begin
                    cmd.pidx = CT_INC;
                    if (sts.pidx_next_le_pic) begin act = A_BITS; tgt = S_USEDCURR; end
                    else begin
                        cmd.pc = PC_NEXT; cmd.li = LI_INC;
                        act = A_GO; tgt = S_RPS;
                    end
                end
                S_NNEG: begin cmd.np = NP_LOAD; act = A_UE; tgt = S_NPOS; end
                S_NPOS: begin
                    if (sts.sum_over) act = A_STOP_ERR;
                    else begin
                        cmd.pc = PC_SUM; cmd.pidx = CT_ZERO;
                        if (sts.sum_nz) begin act = A_UE; tgt = S_DPOC; end
                        else begin cmd.li = LI_INC; act = A_GO; tgt = S_RPS; end
                    end
                end
                S_DPOC: begin act = A_BITS; tgt = S_DUSED; end
                S_DUSED: begin
                    cmd.pidx = CT_INC;
                    if (sts.pidx_next_lt_pic) begin act = A_UE; tgt = S_DPOC; end
                    else begin cmd.li = LI_INC; act = A_GO; tgt = S_RPS; end
                end
                S_LTFLAG: begin
                    if (sts.v_nz) begin act = A_UE; tgt = S_NUMLT; end
                    else begin act = A_BITS; len = LEN_3; tgt = S_VUI; end
                end
                S_NUMLT: begin
                    if (sts.v_over) act = A_STOP_ERR;
                    else begin
                        cmd.limit_load = 1'b1; cmd.li = LI_ZERO; act = A_BITS;
                        if (sts.v_nz) begin len = LEN_LT; tgt = S_LT; end
                        else begin len = LEN_3; tgt = S_VUI; end
                    end
                end
                S_LT: begin
                    cmd.li = LI_INC; act = A_BITS;
                    if (sts.li_next_lt_limit) begin len = LEN_LT; tgt = S_LT; end
                    else begin len = LEN_3; tgt = S_VUI; end
                end
                S_VUI: begin
                    if (sts.v_bit0) begin act = A_BITS; tgt = S_ARFLAG; end
                    else act = A_STOP;
                end
                S_ARFLAG: begin
                    act = A_BITS;
                    if (sts.v_nz) begin len = LEN_8; tgt = S_ARIDC; end
                    else tgt = S_OVFLAG;
                end
                S_ARIDC: begin
                    act = A_BITS;
                    if (sts.v_eq_ff) begin len = LEN_32; tgt = S_SAR; end
                    else tgt = S_OVFLAG;
                end
                S_SAR: begin act = A_BITS; tgt = S_OVFLAG; end
                S_OVFLAG: begin
                    act = A_BITS;
                    tgt = sts.v_nz ? S_OVAPP : S_VSFLAG;
                end
                S_OVAPP: begin act = A_BITS; tgt = S_VSFLAG; end
                S_VSFLAG: begin
                    if (sts.v_nz) begin act = A_BITS; len = LEN_3; tgt = S_VFMT; end
                    else act = A_STOP;
                end
                S_VFMT: begin act = A_BITS; tgt = S_FR; end
                S_FR: begin cmd.put = PUT_FR; act = A_BITS; tgt = S_CDFLAG; end
                S_CDFLAG: begin
                    if (sts.v_nz) begin
                        cmd.put = PUT_CD; act = A_BITS; len = LEN_8; tgt = S_PRIM;
                    end else act = A_STOP;
                end
                S_PRIM: begin cmd.put = PUT_PRIM; act = A_BITS; len = LEN_8; tgt = S_TRC; end
                S_TRC: begin cmd.put = PUT_TRC; act = A_BITS; len = LEN_8; tgt = S_MAT; end
                S_MAT: begin cmd.put = PUT_MAT; act = A_STOP; end
                default: act = A_STOP;
            endcase
        end else if (sts.bits_left) begin
            // feed one payload bit to the reader
            cmd.shift_bit = 1'b1;
            case (rd_reg)
                RD_BITS, RD_SUFFIX: begin
                    cmd.ro = RO_SHIFT;
                    if (sts.skip_one) begin
                        cmd.cap   = (rd_reg == RD_BITS) ? CAP_BITS : CAP_UE;
                        rd_next   = RD_IDLE;
                        pend_next = 1'b1;
                    end
                end
                RD_PREFIX: begin
                    if (!sts.cur_bit) begin
                        if (sts.zeros_max) act = A_STOP_ERR;
                        else cmd.ro = RO_ZERO_INC;
                    end else if (sts.zeros_zero) begin
                        cmd.cap   = CAP_ZERO;
                        rd_next   = RD_IDLE;
                        pend_next = 1'b1;
                    end else begin
                        cmd.ro  = RO_SUFFIX_START;
                        rd_next = RD_SUFFIX;
                    end
                end
                default: ;
            endcase
        end else if (fin_reg) begin
            // deliver the result and rearm for the next sps
            if (!mval_reg || m_ready) begin
                cmd.out_load = 1'b1;
                cmd.clear    = 1'b1;
                mval_next    = 1'b1;
                fin_next     = 1'b0;
                syn_next     = S_VPS;
                rd_next      = RD_BITS;
            end
        end else if (s_valid) begin
            cmd.load_byte = 1'b1;
            fin_next      = s_last;
        end

        cmd.len = len;
        case (act)
            A_GO: syn_next = tgt;
            A_BITS: begin
                cmd.ro = RO_WANT_BITS; rd_next = RD_BITS;
                syn_next = tgt; pend_next = 1'b0;
            end
            A_UE: begin
                cmd.ro = RO_WANT_UE; rd_next = RD_PREFIX;
                syn_next = tgt; pend_next = 1'b0;
            end
            A_STOP, A_STOP_ERR: begin
                cmd.err_set = (act == A_STOP_ERR);
                rd_next = RD_IDLE; syn_next = S_DONE; pend_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            syn_reg  <= S_VPS;
            rd_reg   <= RD_BITS;
            pend_reg <= 1'b0;
            fin_reg  <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            syn_reg  <= syn_next;
            rd_reg   <= rd_next;
            pend_reg <= pend_next;
            fin_reg  <= fin_next;
            mval_reg <= mval_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/hevc_sps_color_info_parser_unit.sv -----
// top level of the sps color info parser
`default_nettype none
// Parses an SPS RBSP (emulation prevention already removed), one byte per
// transaction, MSB first, and returns one result transaction after the byte
// marked last_byte: chroma format, bit depths, VUI signal type and colour
// description with presence bits, an HDR flag and a malformed status. The
// syntax walker reads one bit per clock through a shared bit reader while no
// syntax step is pending: a byte is first accepted and then shifted in bit by bit,
// with a syntax step in between for each decoded field and for each step that
// advances a loop without reading; the next byte is taken once all of that is
// finished, and after the last byte the result register is loaded.
module hevc_sps_color_info_parser_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire hscip_pkg::in_t   s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hscip_pkg::out_t       m_data
);
    import hscip_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hscip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_byte),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hscip_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_data)
    );

`ifndef SYNTHESIS
    // hdr flag follows the transfer code whenever it was read
    a_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.present_mask[2] |->
            m_data.is_hdr == (m_data.transfer_code == 8'd16 ||
                              m_data.transfer_code == 8'd18))
        else $error("hdr flag does not match transfer code");

    // primaries are only read after a colour description flag and a range flag
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.present_mask[1] |->
            m_data.has_colour_desc && m_data.present_mask[0])
        else $error("primaries present without colour description");

    // an accepted byte keeps the reader busy, so the port is not ready in the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("byte accepted while previous byte still shifting");
`endif

endmodule
`default_nettype wire
